// File: hdl/c2p_pkg.sv
`timescale 1ns / 1ps

package c2p_pkg;

  localparam int FIELD_W = 16;
  localparam int ANGLE_W = 16;
  localparam int MAG_W = 16;
  localparam int GUARD = 8;
  localparam int ZW = 20;
  localparam int TABLE_LEN = 24;
  localparam int ANGLE_SHIFT = 3;
  localparam int GAIN_W = 16;
  localparam int MAG_SHIFT = 16 + GUARD;

  localparam logic signed [ZW-1:0] HALF_PI_Q16 = ZW'(102944);
  localparam logic signed [ZW-1:0] ANGLE_ROUND = ZW'(4);
  localparam logic signed [ZW-1:0] ANGLE_LIMIT = ZW'(25736);
  localparam logic [GAIN_W-1:0] INV_GAIN_Q16 = GAIN_W'(39797);
  localparam logic [MAG_W-1:0] MAG_LIMIT = {MAG_W{1'b1}};

  typedef struct packed {
    logic valid;
    logic zero;
  } c2p_ctl_t;

  function automatic logic signed [ZW-1:0] atan_q16(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:       v = ZW'(51472);
      1:       v = ZW'(30386);
      2:       v = ZW'(16055);
      3:       v = ZW'(8150);
      4:       v = ZW'(4091);
      5:       v = ZW'(2047);
      6:       v = ZW'(1024);
      7:       v = ZW'(512);
      8:       v = ZW'(256);
      9:       v = ZW'(128);
      10:      v = ZW'(64);
      11:      v = ZW'(32);
      12:      v = ZW'(16);
      13:      v = ZW'(8);
      14:      v = ZW'(4);
      15:      v = ZW'(2);
      16:      v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/c2p_in_if.sv
`timescale 1ns / 1ps

interface c2p_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [c2p_pkg::FIELD_W-1:0] x_in;
  logic signed [c2p_pkg::FIELD_W-1:0] y_in;

  modport source (output valid, output x_in, output y_in, input ready);
  modport sink (input valid, input x_in, input y_in, output ready);
endinterface

// File: hdl/c2p_out_if.sv
`timescale 1ns / 1ps

interface c2p_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [c2p_pkg::ANGLE_W-1:0] angle_out;
  logic [c2p_pkg::MAG_W-1:0]          magnitude_out;

  modport source (output valid, output angle_out, output magnitude_out, input ready);
  modport sink (input valid, input angle_out, input magnitude_out, output ready);
endinterface

// File: hdl/c2p_pre.sv
`timescale 1ns / 1ps

module c2p_pre #(
  parameter int DATA_WIDTH = 16,
  parameter int XW = 27
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic [c2p_pkg::FIELD_W-1:0]      x_i,
  input  logic [c2p_pkg::FIELD_W-1:0]      y_i,
  output c2p_pkg::c2p_ctl_t                ctl_o,
  input  logic                             ready_i,
  output logic signed [XW-1:0]             x_o,
  output logic signed [XW-1:0]             y_o,
  output logic signed [c2p_pkg::ZW-1:0]    z_o
);

  logic [DATA_WIDTH-1:0] xt, yt;
  logic signed [XW-1:0] xe, ye, xr, yr;
  logic signed [XW-1:0] x_nxt, y_nxt;
  logic signed [c2p_pkg::ZW-1:0] z_nxt;
  logic zero;
  c2p_pkg::c2p_ctl_t ctl_r;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [c2p_pkg::ZW-1:0] z_r;

  generate
    if (DATA_WIDTH <= c2p_pkg::FIELD_W) begin : g_trim
      assign xt = x_i[DATA_WIDTH-1:0];
      assign yt = y_i[DATA_WIDTH-1:0];
    end else begin : g_pad
      assign xt = {{(DATA_WIDTH - c2p_pkg::FIELD_W){1'b0}}, x_i};
      assign yt = {{(DATA_WIDTH - c2p_pkg::FIELD_W){1'b0}}, y_i};
    end
  endgenerate

  assign xe = XW'($signed(xt));
  assign ye = XW'($signed(yt));

  // Vectors in the left half plane are turned by a quarter turn first.
  always_comb begin
    zero = (xt == '0) && (yt == '0);
    if (xe[XW-1]) begin
      if (!ye[XW-1]) begin
        xr = ye;
        yr = -xe;
        z_nxt = c2p_pkg::HALF_PI_Q16;
      end else begin
        xr = -ye;
        yr = xe;
        z_nxt = -c2p_pkg::HALF_PI_Q16;
      end
    end else begin
      xr = xe;
      yr = ye;
      z_nxt = '0;
    end
    x_nxt = xr <<< c2p_pkg::GUARD;
    y_nxt = yr <<< c2p_pkg::GUARD;
  end

  assign ready_o = !ctl_r.valid || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (ready_o) begin
      ctl_r.valid <= valid_i;
      ctl_r.zero <= zero;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

// File: hdl/c2p_cell.sv
`timescale 1ns / 1ps

module c2p_cell #(
  parameter int STAGE = 0,
  parameter int XW = 27
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  c2p_pkg::c2p_ctl_t                ctl_i,
  output logic                             ready_o,
  input  logic signed [XW-1:0]             x_i,
  input  logic signed [XW-1:0]             y_i,
  input  logic signed [c2p_pkg::ZW-1:0]    z_i,
  output c2p_pkg::c2p_ctl_t                ctl_o,
  input  logic                             ready_i,
  output logic signed [XW-1:0]             x_o,
  output logic signed [XW-1:0]             y_o,
  output logic signed [c2p_pkg::ZW-1:0]    z_o
);

  localparam logic signed [c2p_pkg::ZW-1:0] ATAN_STEP = c2p_pkg::atan_q16(STAGE);

  logic signed [XW-1:0] sx, sy, x_nxt, y_nxt;
  logic signed [c2p_pkg::ZW-1:0] z_nxt;
  c2p_pkg::c2p_ctl_t ctl_r;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [c2p_pkg::ZW-1:0] z_r;

  assign sx = x_i >>> STAGE;
  assign sy = y_i >>> STAGE;

  // Each micro-rotation turns the vector toward the positive x axis.
  always_comb begin
    if (!y_i[XW-1]) begin
      x_nxt = x_i + sy;
      y_nxt = y_i - sx;
      z_nxt = z_i + ATAN_STEP;
    end else begin
      x_nxt = x_i - sy;
      y_nxt = y_i + sx;
      z_nxt = z_i - ATAN_STEP;
    end
  end

  assign ready_o = !ctl_r.valid || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (ready_o) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && ctl_i.valid) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

// File: hdl/c2p_post.sv
`timescale 1ns / 1ps

module c2p_post #(
  parameter int XW = 27
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  c2p_pkg::c2p_ctl_t                    ctl_i,
  output logic                                 ready_o,
  input  logic signed [XW-1:0]                 x_i,
  input  logic signed [c2p_pkg::ZW-1:0]        z_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic signed [c2p_pkg::ANGLE_W-1:0]   angle_o,
  output logic [c2p_pkg::MAG_W-1:0]            mag_o
);

  localparam int PW = XW - 1 + c2p_pkg::GAIN_W;
  localparam int HW = PW + 1 - c2p_pkg::MAG_SHIFT;

  logic signed [c2p_pkg::ZW-1:0] zr;
  logic signed [c2p_pkg::ANGLE_W-1:0] ang_nxt;
  logic [XW-2:0] xc;
  logic [PW-1:0] prod_nxt;

  logic va_r;
  logic [PW-1:0] prod_r;
  logic signed [c2p_pkg::ANGLE_W-1:0] ang_a_r;
  logic rdy_a;

  logic [PW:0] rsum;
  logic [HW-1:0] hi;
  logic [c2p_pkg::MAG_W-1:0] mag_nxt;

  logic vb_r;
  logic signed [c2p_pkg::ANGLE_W-1:0] ang_b_r;
  logic [c2p_pkg::MAG_W-1:0] mag_b_r;

  assign zr = (z_i + c2p_pkg::ANGLE_ROUND) >>> c2p_pkg::ANGLE_SHIFT;

  always_comb begin
    if (ctl_i.zero) begin
      ang_nxt = '0;
    end else if (zr > c2p_pkg::ANGLE_LIMIT) begin
      ang_nxt = c2p_pkg::ANGLE_W'(c2p_pkg::ANGLE_LIMIT);
    end else if (zr < -c2p_pkg::ANGLE_LIMIT) begin
      ang_nxt = c2p_pkg::ANGLE_W'(-c2p_pkg::ANGLE_LIMIT);
    end else begin
      ang_nxt = c2p_pkg::ANGLE_W'(zr);
    end
  end

  assign xc = x_i[XW-1] ? '0 : x_i[XW-2:0];
  assign prod_nxt = PW'(xc) * PW'(c2p_pkg::INV_GAIN_Q16);

  assign ready_o = !va_r || rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (ready_o) begin
      va_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && ctl_i.valid) begin
      prod_r <= prod_nxt;
      ang_a_r <= ang_nxt;
    end
  end

  assign rsum = {1'b0, prod_r} + ((PW + 1)'(1) << (c2p_pkg::MAG_SHIFT - 1));
  assign hi = rsum[PW:c2p_pkg::MAG_SHIFT];

  always_comb begin
    if (hi > HW'(c2p_pkg::MAG_LIMIT)) begin
      mag_nxt = c2p_pkg::MAG_LIMIT;
    end else begin
      mag_nxt = c2p_pkg::MAG_W'(hi);
    end
  end

  assign rdy_a = !vb_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (rdy_a) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && va_r) begin
      ang_b_r <= ang_a_r;
      mag_b_r <= mag_nxt;
    end
  end

  assign valid_o = vb_r;
  assign angle_o = ang_b_r;
  assign mag_o = mag_b_r;

endmodule

// File: hdl/cartesian_to_polar_core.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake      Payload
// in_s     input      valid / ready  x_in, y_in (signed)
// out_m    output     valid / ready  angle_out (signed Q3.13), magnitude_out
//
// One item is accepted per cycle unless a stalled output has filled the chain.
// The pipeline is one setup cell, ITERATIONS rotation cells and two output cells.
// Each cell passes its item on whenever the next cell is empty or moving.
// A stalled output fills the chain from the end; empty cells keep accepting.
// Synchronous active-low reset empties every cell.

module cartesian_to_polar_core #(
  parameter int ITERATIONS = 16,
  parameter int DATA_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  c2p_in_if.sink     in_s,
  c2p_out_if.source  out_m
);

  localparam int XW = DATA_WIDTH + c2p_pkg::GUARD + 3;

  c2p_pkg::c2p_ctl_t ctl_c [0:ITERATIONS];
  logic ready_c [0:ITERATIONS];
  logic signed [XW-1:0] x_c [0:ITERATIONS];
  logic signed [XW-1:0] y_c [0:ITERATIONS];
  logic signed [c2p_pkg::ZW-1:0] z_c [0:ITERATIONS];

  c2p_pre #(
    .DATA_WIDTH(DATA_WIDTH),
    .XW(XW)
  ) u_pre (
    .clk(clk),
    .rst_n(rst_n),
    .valid_i(in_s.valid),
    .ready_o(in_s.ready),
    .x_i(in_s.x_in),
    .y_i(in_s.y_in),
    .ctl_o(ctl_c[0]),
    .ready_i(ready_c[0]),
    .x_o(x_c[0]),
    .y_o(y_c[0]),
    .z_o(z_c[0])
  );

  generate
    for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
      c2p_cell #(
        .STAGE(i),
        .XW(XW)
      ) u_cell (
        .clk(clk),
        .rst_n(rst_n),
        .ctl_i(ctl_c[i]),
        .ready_o(ready_c[i]),
        .x_i(x_c[i]),
        .y_i(y_c[i]),
        .z_i(z_c[i]),
        .ctl_o(ctl_c[i+1]),
        .ready_i(ready_c[i+1]),
        .x_o(x_c[i+1]),
        .y_o(y_c[i+1]),
        .z_o(z_c[i+1])
      );
    end
  endgenerate

  c2p_post #(
    .XW(XW)
  ) u_post (
    .clk(clk),
    .rst_n(rst_n),
    .ctl_i(ctl_c[ITERATIONS]),
    .ready_o(ready_c[ITERATIONS]),
    .x_i(x_c[ITERATIONS]),
    .z_i(z_c[ITERATIONS]),
    .valid_o(out_m.valid),
    .ready_i(out_m.ready),
    .angle_o(out_m.angle_out),
    .mag_o(out_m.magnitude_out)
  );

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_m.valid)
    else $error("Result valid right after reset.");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_m.valid |-> (out_m.angle_out <= 16'sd25736) && (out_m.angle_out >= -16'sd25736))
    else $error("Angle outside of [-pi, pi].");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_s.ready |-> (out_m.valid && !out_m.ready))
    else $error("Input stalled while the output side is free.");

  a_zero_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_c[0].valid && ctl_c[0].zero) |-> (x_c[0] == '0) && (z_c[0] == '0))
    else $error("Zero vector entered the chain with nonzero state.");
`endif

endmodule

// File: verif/cartesian_to_polar_core_test.sv
`timescale 1ns / 1ps

module cartesian_to_polar_core_test;

  localparam int ITERS = 16;
  localparam int VEC_W = 16;
  localparam int LATENCY = ITERS + 3;
  localparam int STUCK_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 190;
  localparam longint HALF_PI = 102944;
  localparam longint ANGLE_MAX = 25736;
  localparam longint MAG_MAX = 65535;
  localparam longint GAIN_COMP = 39797;
  localparam int EXTRA_BITS = 8;

  typedef struct packed {
    logic signed [c2p_pkg::ANGLE_W-1:0] angle;
    logic [c2p_pkg::MAG_W-1:0]          mag;
  } polar_t;

  localparam longint ARCTAN_STEP [24] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2,
    1, 0, 0, 0, 0, 0, 0, 0
  };

  logic clk;
  logic rst_n;

  c2p_in_if  vec_ch ();
  c2p_out_if polar_ch ();

  cartesian_to_polar_core #(
    .ITERATIONS(ITERS),
    .DATA_WIDTH(VEC_W)
  ) u_top (
    .clk  (clk),
    .rst_n(rst_n),
    .in_s (vec_ch),
    .out_m(polar_ch)
  );

  polar_t polar_expected[$];
  int     mismatches = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     stuck_cycles = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic polar_t polar_of(input logic signed [VEC_W-1:0] xv,
                                      input logic signed [VEC_W-1:0] yv);
    longint x, y, z, nx, ny, ang, mag, sx, sy;
    polar_t r;
    r.angle = '0;
    r.mag = '0;
    if (xv == 0 && yv == 0) begin
      return r;
    end
    z = 0;
    if (xv < 0) begin
      if (yv >= 0) begin
        x = longint'(yv);
        y = -longint'(xv);
        z = HALF_PI;
      end else begin
        x = -longint'(yv);
        y = longint'(xv);
        z = -HALF_PI;
      end
    end else begin
      x = longint'(xv);
      y = longint'(yv);
    end
    x = x * (longint'(1) << EXTRA_BITS);
    y = y * (longint'(1) << EXTRA_BITS);
    for (int i = 0; i < ITERS && i < 24; i++) begin
      sy = y >>> i;
      sx = x >>> i;
      if (y >= 0) begin
        nx = x + sy;
        ny = y - sx;
        z = z + ARCTAN_STEP[i];
      end else begin
        nx = x - sy;
        ny = y + sx;
        z = z - ARCTAN_STEP[i];
      end
      x = nx;
      y = ny;
    end
    ang = (z + 4) >>> 3;
    if (ang > ANGLE_MAX) ang = ANGLE_MAX;
    if (ang < -ANGLE_MAX) ang = -ANGLE_MAX;
    if (x < 0) x = 0;
    mag = (x * GAIN_COMP + (longint'(1) << (15 + EXTRA_BITS))) >>> (16 + EXTRA_BITS);
    if (mag > MAG_MAX) mag = MAG_MAX;
    if (mag < 0) mag = 0;
    r.angle = ang[c2p_pkg::ANGLE_W-1:0];
    r.mag = mag[c2p_pkg::MAG_W-1:0];
    return r;
  endfunction

  function automatic logic signed [VEC_W-1:0] random_component();
    logic signed [VEC_W-1:0] v;
    case ($urandom_range(9))
      5, 6:    v = VEC_W'($signed($urandom_range(64)) - 32);
      7:       v = '0;
      8:       v = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      9:       v = $urandom_range(1) ? 16'sd1 : -16'sd1;
      default: v = VEC_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_vector(input logic signed [VEC_W-1:0] xv,
                             input logic signed [VEC_W-1:0] yv);
    while ($urandom_range(99) < send_idle_pct) begin
      vec_ch.valid <= 1'b0;
      @(posedge clk);
    end
    vec_ch.valid <= 1'b1;
    vec_ch.x_in  <= xv;
    vec_ch.y_in  <= yv;
    do @(posedge clk); while (!vec_ch.ready);
    polar_expected.push_back(polar_of(xv, yv));
  endtask

  task automatic stop_sending();
    vec_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (polar_expected.size() != 0) @(posedge clk);
  endtask

  task automatic test_corner_vectors();
    logic signed [VEC_W-1:0] xs[24];
    logic signed [VEC_W-1:0] ys[24];
    send_idle_pct = 0;
    recv_stall_pct = 0;
    xs = '{0, 16'sh7fff, 16'sh8000, 0, 0, 16'sh7fff, 16'sh8000, 16'sh8000,
           16'sh7fff, -1, -1, 1, 0, 0, -1, 1,
           16'sh8000, -1, 16'sh8000, 3, -5, 16'sh7fff, -100, 1};
    ys = '{0, 0, 0, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
           16'sh8000, 0, -1, 0, 1, -1, 1, -1,
           -1, 16'sh8000, 1, -4, 12, 1, -100, 16'sh7fff};
    for (int i = 0; i < 24; i++) begin
      send_vector(xs[i], ys[i]);
    end
    stop_sending();
    wait_drained();
  endtask

  task automatic test_random_vectors(input int idle_pct, input int stall_pct,
                                     input int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      send_vector(random_component(), random_component());
    end
    stop_sending();
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 0;
    recv_stall_pct = 50;
    for (int i = 0; i < 20; i++) begin
      send_vector(random_component(), random_component());
    end
    stop_sending();
    wait_drained();
    for (int i = 0; i < 20; i++) begin
      send_vector(VEC_W'($urandom), VEC_W'($urandom));
    end
    stop_sending();
  endtask

  always @(posedge clk) begin
    polar_t want;
    polar_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (polar_ch.valid && polar_ch.ready) begin
      if (polar_expected.size() == 0) begin
        $display("%0t: unexpected item angle %0d magnitude %0d", $realtime,
                 polar_ch.angle_out, polar_ch.magnitude_out);
        mismatches++;
      end else begin
        want = polar_expected.pop_front();
        if (polar_ch.angle_out !== want.angle) begin
          $display("%0t: angle expected %0d actual %0d", $realtime,
                   want.angle, polar_ch.angle_out);
          mismatches++;
        end
        if (polar_ch.magnitude_out !== want.mag) begin
          $display("%0t: magnitude expected %0d actual %0d", $realtime,
                   want.mag, polar_ch.magnitude_out);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((vec_ch.valid && vec_ch.ready) || (polar_ch.valid && polar_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    vec_ch.valid = 1'b0;
    vec_ch.x_in = '0;
    vec_ch.y_in = '0;
    polar_ch.ready = 1'b0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_vectors();
    test_random_vectors(0, 0, RANDOM_ITEMS);
    test_random_vectors(88, 0, RANDOM_ITEMS);
    test_random_vectors(0, 88, RANDOM_ITEMS);
    test_drain_pause();
    test_random_vectors(6, 6, RANDOM_ITEMS);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (polar_expected.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
